[rtl/pbtc_pkg.sv]
// Shared types and constants for the programmable byte transform chain.
package pbtc_pkg;

   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_INC    = 4'd1,
      OP_DEC    = 4'd2,
      OP_ADD    = 4'd3,
      OP_SUB    = 4'd4,
      OP_ADDCNT = 4'd5,
      OP_SUBCNT = 4'd6,
      OP_XOR    = 4'd7,
      OP_ROR    = 4'd8,
      OP_ROL    = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_RUN,
      ST_DONE
   } state_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COUNT    = 2'd2;

   localparam logic REQ_STEP_WRITE = 1'b0;
   localparam logic REQ_TRANSFORM  = 1'b1;

endpackage

[rtl/pbtc_alu.sv]
// Shared byte unit that applies one program step, or its inverse, to a byte.
module pbtc_alu
   import pbtc_pkg::*;
(
   input  logic [3:0] step_op,
   input  logic [7:0] step_data,
   input  logic       inverse,
   input  logic [7:0] value,
   input  logic [7:0] count,
   output logic [7:0] result
);

   op_type      op;
   op_type      op_eff;
   logic [15:0] ror_wide;
   logic [15:0] rol_wide;

   assign op       = op_type'(step_op);
   assign ror_wide = {value, value} >> step_data[2:0];
   assign rol_wide = {value, value} << step_data[2:0];

   always_comb begin
      op_eff = op;
      if (inverse) begin
         unique case (op)
            OP_INC:    op_eff = OP_DEC;
            OP_DEC:    op_eff = OP_INC;
            OP_ADD:    op_eff = OP_SUB;
            OP_SUB:    op_eff = OP_ADD;
            OP_ADDCNT: op_eff = OP_SUBCNT;
            OP_SUBCNT: op_eff = OP_ADDCNT;
            OP_ROR:    op_eff = OP_ROL;
            OP_ROL:    op_eff = OP_ROR;
            default:   op_eff = op;
         endcase
      end
   end

   always_comb begin
      unique case (op_eff)
         OP_INC:    result = value + 8'd1;
         OP_DEC:    result = value - 8'd1;
         OP_ADD:    result = value + step_data;
         OP_SUB:    result = value - step_data;
         OP_ADDCNT: result = value + count;
         OP_SUBCNT: result = value - count;
         OP_XOR:    result = value ^ step_data;
         OP_ROR:    result = ror_wide[7:0];
         OP_ROL:    result = rol_wide[15:8];
         default:   result = value;
      endcase
   end

endmodule

[rtl/programmable_byte_transform_chain.sv]
// Top level of the programmable byte transform chain.
//
// Usage: the req_ stream carries two kinds of transaction, chosen by
// req_tuser. A step write (req_tuser = 0) stores one op and data byte in the
// program memory as it is accepted and returns nothing. A transform
// (req_tuser = 1) runs one byte through the program and returns one byte on
// the rsp_ stream. The csr_ port sets decode mode, program length and the
// counter reload value; write it only while the block is idle.
// A transform of a program of L steps (L clamped to PROGRAM_DEPTH) holds
// req_tready low until its result is taken: when L > 0, a memory read in
// ST_PRIME, then one step per cycle through the shared byte unit in ST_RUN,
// then the result in ST_DONE; when L = 0, ST_DONE only. Every step of every
// byte goes through that one byte unit.
// The result stays on rsp_tdata with rsp_tvalid high until rsp_tready is
// seen; no new transaction is taken meanwhile.
// Reset clears the sequencer, the counter and the CSRs; program memory
// content is undefined until written.
module programmable_byte_transform_chain
   import pbtc_pkg::*;
#(
   parameter int unsigned PROGRAM_DEPTH = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // step_index[5:0], step_op[9:6], step_data[17:10], data_byte[25:18],
   // restart[26], zero[31:27]
   input  logic [31:0]            req_tdata,
   // req_type[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_byte[7:0]
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int unsigned AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int unsigned LW = $clog2(PROGRAM_DEPTH + 1);
   localparam int unsigned CW = (LW > 7) ? LW : 7;
   localparam logic [AW-1:0] LastAddr = AW'(PROGRAM_DEPTH - 1);

   logic [5:0]  step_index;
   logic [3:0]  step_op;
   logic [7:0]  step_data;
   logic [7:0]  data_byte;
   logic        restart;

   assign step_index = req_tdata[5:0];
   assign step_op    = req_tdata[9:6];
   assign step_data  = req_tdata[17:10];
   assign data_byte  = req_tdata[25:18];
   assign restart    = req_tdata[26];

   state_type   state_ff, state_in;
   logic        decode_mode_ff;
   logic [6:0]  program_length_ff;
   logic [7:0]  start_count_ff;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  value_ff, value_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [LW-1:0] remain_ff, remain_in;
   logic [11:0] rd_ff;
   logic [11:0] mem [PROGRAM_DEPTH];

   logic        req_fire;
   logic        rsp_fire;
   logic        mem_we;
   logic [8:0]  index_ext;
   logic [CW-1:0] len_wide;
   logic [LW-1:0] len_eff;
   logic [LW-1:0] len_last;
   logic [AW-1:0] addr_next;
   logic [7:0]  alu_result;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign index_ext = {3'd0, step_index};
   assign mem_we    = req_fire && (req_tuser == REQ_STEP_WRITE)
                      && (index_ext < 9'(PROGRAM_DEPTH));

   assign len_wide = (CW'(program_length_ff) > CW'(PROGRAM_DEPTH))
                     ? CW'(PROGRAM_DEPTH) : CW'(program_length_ff);
   assign len_eff  = len_wide[LW-1:0];
   assign len_last = len_eff - LW'(1);

   always_comb begin
      if (decode_mode_ff) begin
         addr_next = (addr_ff == LastAddr) ? '0 : addr_ff + AW'(1);
      end else begin
         addr_next = (addr_ff == '0) ? LastAddr : addr_ff - AW'(1);
      end
   end

   pbtc_alu u_alu (
      .step_op   (rd_ff[11:8]),
      .step_data (rd_ff[7:0]),
      .inverse   (decode_mode_ff),
      .value     (value_ff),
      .count     (count_ff),
      .result    (alu_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_TRANSFORM)) begin
               state_in = (len_eff == '0) ? ST_DONE : ST_PRIME;
            end
         end
         ST_PRIME: state_in = ST_RUN;
         ST_RUN: begin
            if (remain_ff == LW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_DONE);
      rsp_tdata  = value_ff;
      value_in   = value_ff;
      addr_in    = addr_ff;
      remain_in  = remain_ff;
      count_in   = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_TRANSFORM)) begin
               value_in  = data_byte;
               remain_in = len_eff;
               addr_in   = decode_mode_ff ? '0 : len_last[AW-1:0];
               if (restart) begin
                  count_in = start_count_ff;
               end
            end
         end
         ST_PRIME: addr_in = addr_next;
         ST_RUN: begin
            value_in  = alu_result;
            remain_in = remain_ff - LW'(1);
            addr_in   = addr_next;
         end
         ST_DONE: begin
            if (rsp_fire) begin
               count_in = count_ff - 8'd1;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         count_ff          <= '0;
         decode_mode_ff    <= 1'b0;
         program_length_ff <= '0;
         start_count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DECODE_MODE:    decode_mode_ff    <= csr_data[0];
               CSR_PROGRAM_LENGTH: program_length_ff <= csr_data[6:0];
               CSR_START_COUNT:    start_count_ff    <= csr_data;
               default:            start_count_ff    <= start_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[index_ext[AW-1:0]] <= {step_op, step_data};
      end
      rd_ff <= mem[addr_ff];
   end

endmodule
